### sv/hcut_pkg.sv
package hcut_pkg;

  localparam int TableDepth  = 4096;
  localparam int TableAw     = $clog2(TableDepth);
  localparam int TableCw     = TableAw + 1;
  localparam int RecentDepth = 16;
  localparam int RecentAw    = (RecentDepth > 1) ? $clog2(RecentDepth) : 1;
  localparam int RecentCw    = $clog2(RecentDepth + 1);

  localparam int CodeW  = 24;
  localparam int CountW = 16;
  localparam int ScoreW = 20;

  localparam logic [CodeW-1:0] DistTopMask = 24'hff0000;
  localparam logic [CodeW-1:0] DistMidMask = 24'hffff00;
  localparam logic [CodeW-1:0] CatTopMask  = 24'h00f000;
  localparam logic [CodeW-1:0] CatMidMask  = 24'h00ff00;

  // register indexes
  localparam logic [1:0] RegCodeMode    = 2'd0;
  localparam logic [1:0] RegEntryCount  = 2'd1;
  localparam logic [1:0] RegRecentCount = 2'd2;

  // item kinds
  localparam logic [1:0] KindLoadEntry  = 2'd0;
  localparam logic [1:0] KindLoadRecent = 2'd1;
  localparam logic [1:0] KindUse        = 2'd2;
  localparam logic [1:0] KindScore      = 2'd3;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [CountW-1:0] cnt;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SETUP,
    S_PROBE,
    S_CMP,
    S_BUMP,
    S_NEXT,
    S_RSCAN,
    S_RUPD,
    S_DONE
  } state_e;

endpackage

### sv/hierarchical_code_use_tracker_unit.sv
// channel | valid      | ready      | payload
// in      | in_valid_i | in_ready_o | kind_i slot_index_i code_value_i use_count_in_i
// out     | out_valid_o| out_ready_i| found_o score_tenths_o
// cfg     | cfg_we_i   | (none)     | cfg_index_i cfg_wdata_i
//
// one item at a time; a load writes one table entry or recent slot; a use or score
// item runs up to three binary searches (up to 13 probes each, one table port),
// a bump of each found counter for a use, then a recent list scan if the code is found
// reset sets control and config to defaults and clears the recent list; table contents undefined
// the output register holds a result until it is taken; a new item is taken
// once the sequencer is back in idle
module hierarchical_code_use_tracker_unit
  import hcut_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [12:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [11:0]       slot_index_i,
  input  logic [CodeW-1:0]  code_value_i,
  input  logic [CountW-1:0] use_count_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic [ScoreW-1:0] score_tenths_o
);

  state_e state_q, state_d;

  logic              mode_q;
  logic [12:0]       entry_count_q;
  logic [4:0]        recent_count_q;

  logic [1:0]          kind_q;
  logic [11:0]         slot_q;
  logic [CodeW-1:0]    code_q;
  logic [CountW-1:0]   cnt_q;
  logic [TableCw-1:0]  lo_q, lo_d, hx_q, hx_d;
  logic [1:0]          ph_q, ph_d;
  logic                pfound_q, pfound_d;
  logic                found_q, found_d;
  logic [TableAw-1:0]  idx_q, idx_d;
  logic [CountW-1:0]   hcnt_q, hcnt_d;
  logic [ScoreW-1:0]   acc_q, acc_d;
  logic [RecentCw-1:0] ri_q, ri_d;
  logic                rhit_q, rhit_d;

  logic              ovalid_q;
  logic              ofound_q;
  logic [ScoreW-1:0] oscore_q;

  logic [CodeW-1:0] rec_code_q [RecentDepth];
  logic [RecentDepth-1:0] rec_val_q;

  entry_t mem [TableDepth];
  entry_t rd_q;
  logic               mem_we;
  logic [TableAw-1:0] mem_addr;
  entry_t             mem_wdata;

  logic in_xfer;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // effective sizes
  logic [TableCw-1:0]  n_ent;
  logic [RecentCw-1:0] n_rec;
  always_comb begin
    if (entry_count_q > 13'(TableDepth)) n_ent = TableCw'(TableDepth);
    else n_ent = TableCw'(entry_count_q);
    if (recent_count_q == 5'd0) n_rec = RecentCw'(1);
    else if (recent_count_q > 5'(RecentDepth)) n_rec = RecentCw'(RecentDepth);
    else n_rec = RecentCw'(recent_count_q);
  end

  // search target: the code, then its mid prefix, then its top prefix
  logic [CodeW-1:0] tgt;
  always_comb begin
    case (ph_q)
      2'd0:    tgt = code_q;
      2'd1:    tgt = code_q & (mode_q ? CatMidMask : DistMidMask);
      default: tgt = code_q & (mode_q ? CatTopMask : DistTopMask);
    endcase
  end

  logic [TableCw:0]   mid_sum;
  logic [TableAw-1:0] mid;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hx_q} - 1'b1;
  assign mid     = mid_sum[TableAw:1];

  logic              rec_match;
  logic [RecentAw-1:0] ri_idx;
  assign ri_idx    = ri_q[RecentAw-1:0];
  assign rec_match = rec_val_q[ri_idx] && (rec_code_q[ri_idx] == code_q);

  logic [ScoreW-1:0] hcnt_x;
  logic [ScoreW-1:0] rec_diff;
  assign hcnt_x   = ScoreW'(hcnt_q);
  assign rec_diff = ScoreW'(n_rec - ri_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (kind_i == KindLoadEntry || kind_i == KindLoadRecent) state_d = S_LOAD;
          else state_d = S_SETUP;
        end
      end
      S_LOAD: state_d = S_DONE;
      S_SETUP: begin
        if (ph_q != 2'd0 && tgt == code_q) state_d = S_NEXT;
        else state_d = S_PROBE;
      end
      S_PROBE: begin
        if (lo_q < hx_q) state_d = S_CMP;
        else state_d = S_NEXT;
      end
      S_CMP: begin
        if (rd_q.code == tgt) state_d = (kind_q == KindUse) ? S_BUMP : S_NEXT;
        else state_d = S_PROBE;
      end
      S_BUMP: state_d = S_NEXT;
      S_NEXT: begin
        if (ph_q == 2'd0 && !pfound_q) state_d = S_DONE;
        else if (ph_q == 2'd2) state_d = S_RSCAN;
        else state_d = S_SETUP;
      end
      S_RSCAN: begin
        if (kind_q == KindUse) begin
          if (!(ri_q < n_rec && rec_val_q[ri_idx]) || rec_match) state_d = S_RUPD;
        end else begin
          if (!(ri_q < n_rec) || rec_match) state_d = S_DONE;
        end
      end
      S_RUPD: state_d = S_DONE;
      S_DONE: begin
        if (!ovalid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and table port
  always_comb begin
    lo_d      = lo_q;
    hx_d      = hx_q;
    ph_d      = ph_q;
    pfound_d  = pfound_q;
    found_d   = found_q;
    idx_d     = idx_q;
    hcnt_d    = hcnt_q;
    acc_d     = acc_q;
    ri_d      = ri_q;
    rhit_d    = rhit_q;
    mem_we    = 1'b0;
    mem_addr  = mid;
    mem_wdata = '{code: code_q, cnt: cnt_q};
    case (state_q)
      S_IDLE: begin
        ph_d    = 2'd0;
        found_d = 1'b0;
        acc_d   = '0;
      end
      S_LOAD: begin
        mem_addr = slot_q[TableAw-1:0];
        mem_we   = (kind_q == KindLoadEntry);
      end
      S_SETUP: begin
        lo_d     = '0;
        hx_d     = n_ent;
        pfound_d = 1'b0;
      end
      S_CMP: begin
        if (rd_q.code == tgt) begin
          pfound_d = 1'b1;
          idx_d    = mid;
          hcnt_d   = rd_q.cnt;
        end else if (rd_q.code > tgt) begin
          hx_d = TableCw'(mid);
        end else begin
          lo_d = TableCw'(mid) + 1'b1;
        end
      end
      S_BUMP: begin
        mem_we    = 1'b1;
        mem_addr  = idx_q;
        mem_wdata = '{code: tgt,
                      cnt: (hcnt_q == '1) ? hcnt_q : hcnt_q + 1'b1};
      end
      S_NEXT: begin
        if (ph_q == 2'd0) found_d = pfound_q;
        if (kind_q == KindScore && pfound_q) begin
          case (ph_q)
            2'd0:    acc_d = acc_q + (hcnt_x << 2) + hcnt_x;
            2'd1:    acc_d = acc_q + (hcnt_x << 1);
            default: acc_d = acc_q + hcnt_x;
          endcase
        end
        ph_d   = ph_q + 1'b1;
        ri_d   = '0;
        rhit_d = 1'b0;
      end
      S_RSCAN: begin
        if (kind_q == KindUse) begin
          if (ri_q < n_rec && rec_val_q[ri_idx]) begin
            if (rec_match) rhit_d = 1'b1;
            else ri_d = ri_q + 1'b1;
          end
        end else if (ri_q < n_rec) begin
          if (rec_match) acc_d = acc_q + (rec_diff << 2) + rec_diff;
          else ri_d = ri_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // code table and counters, one port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_q <= mem[mem_addr];
  end

  // control and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      mode_q         <= 1'b0;
      entry_count_q  <= '0;
      recent_count_q <= 5'd16;
      ovalid_q       <= 1'b0;
      ph_q           <= '0;
      pfound_q       <= 1'b0;
      found_q        <= 1'b0;
      ri_q           <= '0;
      rhit_q         <= 1'b0;
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      pfound_q <= pfound_d;
      found_q  <= found_d;
      ri_q     <= ri_d;
      rhit_q   <= rhit_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegCodeMode:    mode_q         <= cfg_wdata_i[0];
          RegEntryCount:  entry_count_q  <= cfg_wdata_i;
          RegRecentCount: recent_count_q <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
      if (state_q == S_DONE && (!ovalid_q || out_ready_i)) ovalid_q <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hx_q   <= hx_d;
    idx_q  <= idx_d;
    hcnt_q <= hcnt_d;
    acc_q  <= acc_d;
    if (in_xfer) begin
      kind_q <= kind_i;
      slot_q <= slot_index_i;
      code_q <= code_value_i;
      cnt_q  <= use_count_in_i;
    end
    if (state_q == S_DONE && (!ovalid_q || out_ready_i)) begin
      ofound_q <= found_q;
      oscore_q <= (kind_q == KindScore) ? acc_q : '0;
    end
  end

  // recent list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_val_q <= '0;
      for (int k = 0; k < RecentDepth; k++) rec_code_q[k] <= '0;
    end else if (state_q == S_LOAD && kind_q == KindLoadRecent) begin
      if (slot_q < 12'(RecentDepth)) begin
        rec_code_q[slot_q[RecentAw-1:0]] <= code_q;
        rec_val_q[slot_q[RecentAw-1:0]]  <= 1'b1;
      end
    end else if (state_q == S_RUPD && (!rhit_q || !mode_q)) begin
      for (int k = 1; k < RecentDepth; k++) begin
        if (RecentCw'(k) <= (rhit_q ? ri_q : n_rec - 1'b1)) begin
          rec_code_q[k] <= rec_code_q[k-1];
          rec_val_q[k]  <= rec_val_q[k-1];
        end
      end
      rec_code_q[0] <= code_q;
      rec_val_q[0]  <= 1'b1;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign found_o        = ofound_q;
  assign score_tenths_o = oscore_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o) else $error("ready while busy");
  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (lo_q < hx_q)) else $error("probe outside range");
  a_front_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUPD) |=> rec_val_q[0]) else $error("front slot empty");
`endif

endmodule
